>>> design/cpc_pkg.sv
// cpc_pkg: widths, codes and types shared by the coprime pair counter
// used by cpc_divider, cpc_factor_table and coprime_pair_counter_core
package cpc_pkg;

  localparam int MAX_VALUE = 16383;
  localparam int VAL_W     = $clog2(MAX_VALUE + 1);
  localparam int TBL_DEPTH = MAX_VALUE + 1;
  localparam int DIV_W     = 32;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int COUNT_W   = 28;
  // distinct primes of any value up to 65535 never exceed six
  localparam int NPRIM_MAX = 6;
  localparam int KW        = $clog2(NPRIM_MAX + 1);

  localparam logic [VAL_W-1:0] MAX_V = VAL_W'(MAX_VALUE);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] prime;
    logic [VAL_W-1:0] cofactor;
  } fentry_t;

  typedef enum logic [3:0] {
    T_CLEAR,
    T_SV_RD,
    T_SV_CHK,
    T_MK_RD,
    T_MK_CHK,
    T_CF_RD,
    T_CF_CHK,
    T_CJ_RD,
    T_CJ_CHK,
    T_CJ_WR,
    T_DONE
  } tbl_state_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_STEP,
    S_FACT_RD,
    S_FACT_WAIT,
    S_TERM_MUL,
    S_TERM_DIV,
    S_COMMIT,
    S_OUT
  } top_state_t;

endpackage

>>> design/coprime_pair_counter_core.sv
// coprime_pair_counter_core: top level, query sequencer over a walked point
// uses cpc_pkg, cpc_factor_table and cpc_divider
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    first_bound, second_bound, divisor
//   out_     output     out_valid / out_stall  pair_count, status
//
// after reset the table is cleared and sieved; in_stall stays high until then.
// a transaction runs the two bound divisions and then walks one step at a time; per walk
// step the distinct primes of the line index are read from the table and, per inclusion-
// exclusion term, the term's primes are multiplied and n is divided by their product,
// all on one shared divider.
// one transaction at a time; a finished result waits in the output register
module coprime_pair_counter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_first_bound,
  input  logic [31:0]                 in_second_bound,
  input  logic [31:0]                 in_divisor,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cpc_pkg::COUNT_W-1:0] out_pair_count,
  output logic [1:0]                  out_status
);
  import cpc_pkg::*;

  top_state_t state_r, state_nxt;

  logic [DIV_W-1:0]   by_r, by_nxt, bd_r, bd_nxt, qx_r, qx_nxt;
  logic [VAL_W-1:0]   ta_r, ta_nxt, tb_r, tb_nxt;
  logic [VAL_W-1:0]   wa_r, wa_nxt, wb_r, wb_nxt;
  logic [COUNT_W-1:0] wc_r, wc_nxt;
  logic [VAL_W-1:0]   na_r, na_nxt, nb_r, nb_nxt;
  logic [VAL_W-1:0]   m_r, m_nxt, n_r, n_nxt, cur_r, cur_nxt, d_r, d_nxt;
  logic               add_r, add_nxt;
  logic [VAL_W-1:0]   primes_r [NPRIM_MAX];
  logic [VAL_W-1:0]   primes_nxt [NPRIM_MAX];
  logic [KW-1:0]      k_r, k_nxt, idx_r, idx_nxt;
  logic [NPRIM_MAX-1:0] mask_r, mask_nxt, mask_full;
  logic [COUNT_W-1:0] lc_r, lc_nxt, res_count_r, res_count_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               tbl_ready;
  fentry_t            tbl_q;
  logic               div_start, div_short, div_done;
  logic [DIV_W-1:0]   div_num, div_den, div_quo;
  logic [2*VAL_W-1:0] prod;
  logic [VAL_W-1:0]   qy;

  cpc_factor_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (cur_r),
    .rd_data (tbl_q),
    .ready   (tbl_ready)
  );

  cpc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .short_op (div_short),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign mask_full = ~({NPRIM_MAX{1'b1}} << k_r);

  always_comb begin
    state_nxt      = state_r;
    by_nxt         = by_r;
    bd_nxt         = bd_r;
    qx_nxt         = qx_r;
    ta_nxt         = ta_r;
    tb_nxt         = tb_r;
    wa_nxt         = wa_r;
    wb_nxt         = wb_r;
    wc_nxt         = wc_r;
    na_nxt         = na_r;
    nb_nxt         = nb_r;
    m_nxt          = m_r;
    n_nxt          = n_r;
    add_nxt        = add_r;
    cur_nxt        = cur_r;
    d_nxt          = d_r;
    primes_nxt     = primes_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    mask_nxt       = mask_r;
    lc_nxt         = lc_r;
    res_count_nxt  = res_count_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    div_start      = 1'b0;
    div_short      = 1'b0;
    div_num        = by_r;
    div_den        = bd_r;
    prod           = d_r * primes_r[idx_r];
    qy             = div_quo[VAL_W-1:0];

    unique case (state_r)
      S_INIT: if (tbl_ready) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          by_nxt = in_second_bound;
          bd_nxt = in_divisor;
          if (in_divisor == '0) begin
            res_count_nxt  = '0;
            res_status_nxt = ST_DIV_ZERO;
            state_nxt      = S_OUT;
          end else begin
            div_start = 1'b1;
            div_num   = in_first_bound;
            div_den   = in_divisor;
            state_nxt = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        if (div_done) begin
          qx_nxt    = div_quo;
          div_start = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          if (qx_r > DIV_W'(MAX_VALUE) || div_quo > DIV_W'(MAX_VALUE)) begin
            res_count_nxt  = '0;
            res_status_nxt = ST_RANGE;
            state_nxt      = S_OUT;
          end else if (qx_r[VAL_W-1:0] >= qy) begin
            ta_nxt    = qx_r[VAL_W-1:0];
            tb_nxt    = qy;
            state_nxt = S_STEP;
          end else begin
            ta_nxt    = qy;
            tb_nxt    = qx_r[VAL_W-1:0];
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        na_nxt = wa_r;
        nb_nxt = wb_r;
        priority if (wa_r < ta_r) begin
          na_nxt  = wa_r + 1'b1;
          m_nxt   = wa_r + 1'b1;
          n_nxt   = wb_r;
          add_nxt = 1'b1;
        end else if (wa_r > ta_r) begin
          na_nxt  = wa_r - 1'b1;
          m_nxt   = wa_r;
          n_nxt   = wb_r;
          add_nxt = 1'b0;
        end else if (wb_r < tb_r) begin
          nb_nxt  = wb_r + 1'b1;
          m_nxt   = wb_r + 1'b1;
          n_nxt   = wa_r;
          add_nxt = 1'b1;
        end else if (wb_r > tb_r) begin
          nb_nxt  = wb_r - 1'b1;
          m_nxt   = wb_r;
          n_nxt   = wa_r;
          add_nxt = 1'b0;
        end else begin
          res_count_nxt  = wc_r;
          res_status_nxt = ST_OK;
        end
        if (wa_r == ta_r && wb_r == tb_r) begin
          state_nxt = S_OUT;
        end else if (n_nxt == '0) begin
          lc_nxt    = '0;
          state_nxt = S_COMMIT;
        end else if (m_nxt == VAL_W'(1)) begin
          lc_nxt    = COUNT_W'(n_nxt);
          state_nxt = S_COMMIT;
        end else begin
          cur_nxt   = m_nxt;
          k_nxt     = '0;
          state_nxt = S_FACT_RD;
        end
      end
      S_FACT_RD: state_nxt = S_FACT_WAIT;
      S_FACT_WAIT: begin
        primes_nxt[k_r] = tbl_q.prime;
        k_nxt           = k_r + 1'b1;
        if (tbl_q.cofactor == VAL_W'(1)) begin
          mask_nxt  = '0;
          idx_nxt   = '0;
          d_nxt     = VAL_W'(1);
          lc_nxt    = '0;
          state_nxt = S_TERM_MUL;
        end else begin
          cur_nxt   = tbl_q.cofactor;
          state_nxt = S_FACT_RD;
        end
      end
      S_TERM_MUL: begin
        if (idx_r == k_r) begin
          div_start = 1'b1;
          div_short = 1'b1;
          div_num   = DIV_W'(n_r);
          div_den   = DIV_W'(d_r);
          state_nxt = S_TERM_DIV;
        end else begin
          if (mask_r[idx_r]) d_nxt = prod[VAL_W-1:0];
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TERM_DIV: begin
        if (div_done) begin
          // odd number of primes in the term subtracts
          lc_nxt = (^mask_r) ? lc_r - COUNT_W'(qy) : lc_r + COUNT_W'(qy);
          if (mask_r == mask_full) begin
            state_nxt = S_COMMIT;
          end else begin
            mask_nxt  = mask_r + 1'b1;
            idx_nxt   = '0;
            d_nxt     = VAL_W'(1);
            state_nxt = S_TERM_MUL;
          end
        end
      end
      S_COMMIT: begin
        wc_nxt    = add_r ? wc_r + lc_r : wc_r - lc_r;
        wa_nxt    = na_r;
        wb_nxt    = nb_r;
        state_nxt = S_STEP;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = res_count_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      wa_r        <= '0;
      wb_r        <= '0;
      wc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wa_r        <= wa_nxt;
      wb_r        <= wb_nxt;
      wc_r        <= wc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    by_r         <= by_nxt;
    bd_r         <= bd_nxt;
    qx_r         <= qx_nxt;
    ta_r         <= ta_nxt;
    tb_r         <= tb_nxt;
    na_r         <= na_nxt;
    nb_r         <= nb_nxt;
    m_r          <= m_nxt;
    n_r          <= n_nxt;
    add_r        <= add_nxt;
    cur_r        <= cur_nxt;
    d_r          <= d_nxt;
    primes_r     <= primes_nxt;
    k_r          <= k_nxt;
    idx_r        <= idx_nxt;
    mask_r       <= mask_nxt;
    lc_r         <= lc_nxt;
    res_count_r  <= res_count_nxt;
    res_status_r <= res_status_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pair_count = out_count_r;
  assign out_status     = out_status_r;

endmodule

>>> design/cpc_divider.sv
// cpc_divider: restoring divider, one quotient bit per cycle
// full width or short (VAL_W bit numerator) mode; depends on cpc_pkg
module cpc_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      short_op,
  input  logic [cpc_pkg::DIV_W-1:0] num,
  input  logic [cpc_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [cpc_pkg::DIV_W-1:0] quo
);
  import cpc_pkg::*;

  logic [DIV_W-1:0] rem_r, quo_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DIV_W:0]   rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= short_op ? CNT_W'(VAL_W) : CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      // short mode puts the numerator at the top so only VAL_W steps are run
      quo_r <= short_op ? {num[VAL_W-1:0], {(DIV_W-VAL_W){1'b0}}} : num;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> design/cpc_factor_table.sv
// cpc_factor_table: smallest prime and cofactor table, built by a sieve after reset
// clear sweep, smallest prime sieve, then cofactor pass; depends on cpc_pkg
module cpc_factor_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cpc_pkg::VAL_W-1:0] rd_addr,
  output cpc_pkg::fentry_t          rd_data,
  output logic                      ready
);
  import cpc_pkg::*;

  fentry_t mem [TBL_DEPTH];
  fentry_t rd_q;

  tbl_state_t       state_r, state_nxt;
  logic [VAL_W-1:0] i_r, i_nxt;
  logic [VAL_W:0]   j_r, j_nxt;
  logic [VAL_W-1:0] m_r, m_nxt;

  logic             wr_en;
  logic [VAL_W-1:0] wr_addr, seq_addr, mem_addr;
  fentry_t          wr_data;
  logic [2*VAL_W-1:0] sq;
  logic [VAL_W:0]   jn;
  logic [VAL_W-1:0] cof;

  assign mem_addr = (state_r == T_DONE) ? rd_addr : seq_addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[mem_addr];
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    m_nxt     = m_r;
    wr_en     = 1'b0;
    wr_addr   = i_r;
    wr_data   = '0;
    seq_addr  = i_r;
    sq        = i_r * i_r;
    jn        = j_r + {1'b0, i_r};
    cof       = (rd_q.prime == i_r) ? rd_q.cofactor : m_r;
    unique case (state_r)
      T_CLEAR: begin
        wr_en = 1'b1;
        if (i_r == MAX_V) begin
          i_nxt     = VAL_W'(2);
          state_nxt = T_SV_RD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      T_SV_RD: state_nxt = T_SV_CHK;
      T_SV_CHK: begin
        if (rd_q.prime == '0 && sq <= (2*VAL_W)'(MAX_VALUE)) begin
          wr_en     = 1'b1;
          wr_data   = '{prime: i_r, cofactor: '0};
          j_nxt     = sq[VAL_W:0];
          state_nxt = T_MK_RD;
        end else begin
          if (rd_q.prime == '0) begin
            wr_en   = 1'b1;
            wr_data = '{prime: i_r, cofactor: '0};
          end
          if (i_r == MAX_V) begin
            i_nxt     = VAL_W'(2);
            state_nxt = T_CF_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = T_SV_RD;
          end
        end
      end
      T_MK_RD: begin
        seq_addr  = j_r[VAL_W-1:0];
        state_nxt = T_MK_CHK;
      end
      T_MK_CHK: begin
        if (rd_q.prime == '0) begin
          wr_en   = 1'b1;
          wr_addr = j_r[VAL_W-1:0];
          wr_data = '{prime: i_r, cofactor: '0};
        end
        if (jn > {1'b0, MAX_V}) begin
          if (i_r == MAX_V) begin
            i_nxt     = VAL_W'(2);
            state_nxt = T_CF_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = T_SV_RD;
          end
        end else begin
          j_nxt     = jn;
          state_nxt = T_MK_RD;
        end
      end
      T_CF_RD: state_nxt = T_CF_CHK;
      T_CF_CHK: begin
        if (rd_q.prime == i_r) begin
          j_nxt     = {1'b0, i_r};
          m_nxt     = VAL_W'(1);
          state_nxt = T_CJ_RD;
        end else if (i_r == MAX_V) begin
          state_nxt = T_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = T_CF_RD;
        end
      end
      T_CJ_RD: begin
        seq_addr  = j_r[VAL_W-1:0];
        state_nxt = T_CJ_CHK;
      end
      T_CJ_CHK, T_CJ_WR: begin
        if (state_r == T_CJ_CHK && rd_q.prime == i_r) begin
          // fetch the entry of j / p next
          seq_addr  = m_r;
          state_nxt = T_CJ_WR;
        end else begin
          if (state_r == T_CJ_WR) begin
            wr_en   = 1'b1;
            wr_addr = j_r[VAL_W-1:0];
            wr_data = '{prime: i_r, cofactor: cof};
          end
          if (jn > {1'b0, MAX_V}) begin
            if (i_r == MAX_V) begin
              state_nxt = T_DONE;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = T_CF_RD;
            end
          end else begin
            j_nxt     = jn;
            m_nxt     = m_r + 1'b1;
            state_nxt = T_CJ_RD;
          end
        end
      end
      T_DONE: state_nxt = T_DONE;
      default: state_nxt = T_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_CLEAR;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    m_r <= m_nxt;
  end

  assign rd_data = rd_q;
  assign ready   = (state_r == T_DONE);

endmodule
